[rtl/ple_pkg.sv]
// Shared types and constants for the positional list engine.
package ple_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_MOVE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam int POS_W = 11;
    localparam int VAL_W = 32;

    localparam logic signed [VAL_W-1:0] NEG_ONE = -32'sd1;

    typedef struct packed {
        op_t                     operation;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] new_value;
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [POS_W-1:0]        entry_count;
        logic signed [VAL_W-1:0] largest_value;
        status_t                 status;
    } res_t;

endpackage

[rtl/ple_cmd_if.sv]
// Command channel: valid/ready with one command per transfer.
interface ple_cmd_if import ple_pkg::*; ();
    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/ple_res_if.sv]
// Result channel: valid/ready with one result per transfer.
interface ple_res_if import ple_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/positional_list_engine.sv]
// Positional list engine: ordered value list held in one synchronous RAM.
//
//  channel | dir | payload                                             | transfer
//  cmd     | in  | operation, position, new_value                       | valid & ready
//  res     | out | read_value, entry_count, largest_value, status       | valid & ready
//
// One command at a time; count is the length before the command. Read fetches the entry;
// insert shifts the entries from the end down to the position up by one, then writes the
// value (an append writes at once); remove shifts the later entries down by one and then
// rescans the maximum from the RAM one entry per cycle, unless the list empties; move to
// back holds the entry, shifts the later ones down and writes it last. Out-of-range
// commands, a full-list insert and a last-entry move skip to S_DONE; one RAM port pair.
// Reset clears the count and sets the maximum to -1; RAM contents are not cleared.
// A command is taken while an earlier result still waits in the output register;
// a result that is still waiting holds the next one in S_DONE.
module positional_list_engine import ple_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    ple_cmd_if.sink   cmd,
    ple_res_if.source res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_HOLD,
        S_SHIFT,
        S_PUT,
        S_RESCAN,
        S_SCAN,
        S_DONE
    } state_t;

    logic signed [VAL_W-1:0] mem [CAPACITY];
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic signed [VAL_W-1:0] mem_rdata_reg;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic signed [VAL_W-1:0] held_reg, held_next;
    logic [CW-1:0]           count_reg, count_next;
    logic signed [VAL_W-1:0] max_reg, max_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [AW-1:0]           last_reg, last_next;
    logic [AW-1:0]           prev_reg, prev_next;
    logic                    issue_reg, issue_next;
    logic                    pend_reg, pend_next;
    logic                    pend_end_reg, pend_end_next;
    logic                    first_reg, first_next;
    logic signed [VAL_W-1:0] rd_reg, rd_next;
    status_t                 st_reg, st_next;
    logic                    out_valid_reg, out_valid_next;
    res_t                    out_data_reg, out_data_next;

    logic [PW-1:0]           pos_w;
    logic [PW-1:0]           cnt_w;

    assign cmd.ready = (state_reg == S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    assign pos_w = PW'(cmd.data.position);
    assign cnt_w = PW'(count_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        held_next      = held_reg;
        count_next     = count_reg;
        max_next       = max_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        prev_next      = prev_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_end_next  = pend_end_reg;
        first_next     = first_reg;
        rd_next        = rd_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        mem_we    = 1'b0;
        mem_waddr = prev_reg;
        mem_wdata = mem_rdata_reg;
        mem_raddr = idx_reg;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next  = cmd.data.operation;
                    val_next = cmd.data.new_value;
                    pos_next = AW'(cmd.data.position);
                    rd_next  = '0;
                    st_next  = ST_OK;
                    case (cmd.data.operation)
                        OP_INSERT:
                        begin
                            if (pos_w > cnt_w)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end
                            else if (pos_w == cnt_w)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                idx_next   = AW'(count_reg - 1'b1);
                                last_next  = AW'(cmd.data.position);
                                issue_next = 1'b1;
                                pend_next  = 1'b0;
                                state_next = S_SHIFT;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                rd_next    = NEG_ONE;
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                mem_raddr  = AW'(cmd.data.position);
                                state_next = S_READ;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else if (pos_w + 1'b1 == cnt_w)
                            begin
                                count_next = count_reg - 1'b1;
                                state_next = S_RESCAN;
                            end
                            else
                            begin
                                idx_next   = AW'(cmd.data.position) + 1'b1;
                                last_next  = AW'(count_reg - 1'b1);
                                issue_next = 1'b1;
                                pend_next  = 1'b0;
                                state_next = S_SHIFT;
                            end
                        end
                        OP_MOVE:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else if (pos_w + 1'b1 == cnt_w)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                mem_raddr  = AW'(cmd.data.position);
                                state_next = S_HOLD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                rd_next    = mem_rdata_reg;
                state_next = S_DONE;
            end

            S_HOLD:
            begin
                held_next  = mem_rdata_reg;
                idx_next   = pos_reg + 1'b1;
                last_next  = AW'(count_reg - 1'b1);
                issue_next = 1'b1;
                pend_next  = 1'b0;
                state_next = S_SHIFT;
            end

            S_SHIFT:
            begin
                if (issue_reg)
                begin
                    mem_raddr     = idx_reg;
                    pend_next     = 1'b1;
                    prev_next     = idx_reg;
                    pend_end_next = (idx_reg == last_reg);
                    if (idx_reg == last_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else if (op_reg == OP_INSERT)
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata_reg;
                    if (op_reg == OP_INSERT)
                    begin
                        mem_waddr = prev_reg + 1'b1;
                    end
                    else
                    begin
                        mem_waddr = prev_reg - 1'b1;
                    end
                    if (pend_end_reg)
                    begin
                        pend_next = 1'b0;
                        if (op_reg == OP_REMOVE)
                        begin
                            count_next = count_reg - 1'b1;
                            state_next = S_RESCAN;
                        end
                        else
                        begin
                            state_next = S_PUT;
                        end
                    end
                end
            end

            S_PUT:
            begin
                mem_we = 1'b1;
                if (op_reg == OP_INSERT)
                begin
                    mem_waddr  = pos_reg;
                    mem_wdata  = val_reg;
                    count_next = count_reg + 1'b1;
                    if ((count_reg == '0) || (val_reg > max_reg))
                    begin
                        max_next = val_reg;
                    end
                end
                else
                begin
                    mem_waddr = AW'(count_reg - 1'b1);
                    mem_wdata = held_reg;
                end
                state_next = S_DONE;
            end

            S_RESCAN:
            begin
                if (count_reg == '0)
                begin
                    max_next   = NEG_ONE;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = '0;
                    last_next  = AW'(count_reg - 1'b1);
                    issue_next = 1'b1;
                    pend_next  = 1'b0;
                    first_next = 1'b1;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (issue_reg)
                begin
                    mem_raddr     = idx_reg;
                    pend_next     = 1'b1;
                    pend_end_next = (idx_reg == last_reg);
                    if (idx_reg == last_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    first_next = 1'b0;
                    if (first_reg || (mem_rdata_reg > max_reg))
                    begin
                        max_next = mem_rdata_reg;
                    end
                    if (pend_end_reg)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.read_value    = rd_reg;
                    out_data_next.entry_count   = POS_W'(count_reg);
                    out_data_next.largest_value = max_reg;
                    out_data_next.status        = st_reg;
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_INSERT;
            pos_reg       <= '0;
            val_reg       <= '0;
            held_reg      <= '0;
            count_reg     <= '0;
            max_reg       <= NEG_ONE;
            idx_reg       <= '0;
            last_reg      <= '0;
            prev_reg      <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pend_end_reg  <= 1'b0;
            first_reg     <= 1'b0;
            rd_reg        <= '0;
            st_reg        <= ST_OK;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            pos_reg       <= pos_next;
            val_reg       <= val_next;
            held_reg      <= held_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            prev_reg      <= prev_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            pend_end_reg  <= pend_end_next;
            first_reg     <= first_next;
            rd_reg        <= rd_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

[dv/ple_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard that tracks the expected list contents and checks each result transfer.
package ple_tb_pkg;
    import ple_pkg::*;

    class list_scoreboard;
        logic signed [VAL_W-1:0] shadow_list [$];
        res_t due_results [$];
        int capacity;
        int errors;

        function new(int cap);
            capacity = cap;
            errors = 0;
        endfunction

        function int shadow_size();
            return shadow_list.size();
        endfunction

        function int waiting();
            return due_results.size();
        endfunction

        function void note_command(cmd_t c);
            res_t r;
            logic signed [VAL_W-1:0] held;
            int cnt;
            int p;
            cnt = shadow_list.size();
            p = int'(c.position);
            r.read_value = '0;
            r.status = ST_OK;
            case (c.operation)
                OP_INSERT:
                begin
                    if (p > cnt)
                        r.status = ST_RANGE;
                    else if (cnt >= capacity)
                        r.status = ST_FULL;
                    else
                        shadow_list.insert(p, c.new_value);
                end
                OP_READ:
                begin
                    if (p >= cnt)
                    begin
                        r.read_value = NEG_ONE;
                        r.status = ST_RANGE;
                    end
                    else
                        r.read_value = shadow_list[p];
                end
                OP_REMOVE:
                begin
                    if (p >= cnt)
                        r.status = ST_RANGE;
                    else
                        shadow_list.delete(p);
                end
                OP_MOVE:
                begin
                    if (p >= cnt)
                        r.status = ST_RANGE;
                    else
                    begin
                        held = shadow_list[p];
                        shadow_list.delete(p);
                        shadow_list.push_back(held);
                    end
                end
                default:
                begin
                    r.status = ST_OK;
                end
            endcase
            r.entry_count = POS_W'(shadow_list.size());
            if (shadow_list.size() == 0)
                r.largest_value = NEG_ONE;
            else
            begin
                r.largest_value = shadow_list[0];
                foreach (shadow_list[k])
                    if (shadow_list[k] > r.largest_value)
                        r.largest_value = shadow_list[k];
            end
            due_results.push_back(r);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result read_value %0d count %0d largest %0d status %0d",
                         $time, got.read_value, got.entry_count, got.largest_value, got.status);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.read_value !== want.read_value)
            begin
                $display("%0t: read_value expected %0d, got %0d",
                         $time, want.read_value, got.read_value);
                errors++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $display("%0t: entry_count expected %0d, got %0d",
                         $time, want.entry_count, got.entry_count);
                errors++;
            end
            if (got.largest_value !== want.largest_value)
            begin
                $display("%0t: largest_value expected %0d, got %0d",
                         $time, want.largest_value, got.largest_value);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d, got %0d",
                         $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

endpackage

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Top-level testbench for the positional list engine: directed and random commands.
module tb_top;
    import ple_pkg::*;
    import ple_tb_pkg::*;

    localparam int LIST_DEPTH = 1024;
    localparam int RANDOM_ITEMS = 560;
    localparam int CALM_ITEMS = 80;

    logic clk;
    logic rst_n;
    bit calm;
    bit sender_gappy;
    list_scoreboard board;

    ple_cmd_if cmd_ch ();
    ple_res_if res_ch ();

    positional_list_engine #(.CAPACITY(LIST_DEPTH)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (res_ch.valid && res_ch.ready)
                board.check_result(res_ch.data);
            if (cmd_ch.valid && cmd_ch.ready)
                board.note_command(cmd_ch.data);
        end
    end

    initial
    begin
        int pick;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            pick = $urandom_range(0, 19);
            if (!calm && pick < 4)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            else if (pick == 19)
            begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    task automatic send_cmd(input op_t op, input int pos,
                            input logic signed [VAL_W-1:0] val);
        cmd_t c;
        c.operation = op;
        c.position = POS_W'(pos);
        c.new_value = val;
        if (!calm && sender_gappy && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= c;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int cnt;
        int w;
        int ins_w;
        int rem_w;
        int phase_left;
        op_t op;
        int pos;
        logic signed [VAL_W-1:0] val;

        board = new(LIST_DEPTH);
        calm = 1'b0;
        sender_gappy = 1'b1;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_cmd(OP_READ, 0, 0);
        send_cmd(OP_REMOVE, 0, 0);
        send_cmd(OP_MOVE, 0, 0);
        send_cmd(OP_INSERT, 1, 5);
        send_cmd(OP_INSERT, 1024, 5);
        send_cmd(OP_INSERT, 0, 32'sh8000_0000);
        send_cmd(OP_READ, 0, 0);
        send_cmd(OP_INSERT, 1, -1);
        send_cmd(OP_INSERT, 0, 32'sh7fff_ffff);
        send_cmd(OP_INSERT, 1, 0);
        send_cmd(OP_INSERT, 4, 32'sh5555_5555);
        send_cmd(OP_INSERT, 6, 9);
        send_cmd(OP_READ, 4, 0);
        send_cmd(OP_READ, 5, 0);
        send_cmd(OP_READ, 1024, 0);
        send_cmd(OP_MOVE, 4, 0);
        send_cmd(OP_MOVE, 0, 0);
        send_cmd(OP_REMOVE, 4, 0);
        send_cmd(OP_REMOVE, 4, 0);
        send_cmd(OP_MOVE, 1024, 0);
        send_cmd(OP_READ, 2, 32'shaaaa_aaaa);
        send_cmd(OP_REMOVE, 0, 0);

        phase_left = 0;
        ins_w = 15;
        rem_w = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                cmd_ch.valid <= 1'b0;
                @(negedge clk);
                while (board.waiting() != 0) @(negedge clk);
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(30, 80);
                if (ins_w == 60)
                begin
                    ins_w = 15;
                    rem_w = 50;
                end
                else
                begin
                    ins_w = 60;
                    rem_w = 10;
                end
                sender_gappy = ($urandom_range(0, 2) != 0);
            end
            phase_left--;
            cnt = board.shadow_size();

            w = $urandom_range(0, 99);
            if (w < ins_w)
                op = OP_INSERT;
            else if (w < ins_w + 15)
                op = OP_READ;
            else if (w < ins_w + 15 + rem_w)
                op = OP_REMOVE;
            else
                op = OP_MOVE;

            w = $urandom_range(0, 99);
            if (w < 10)
                pos = 0;
            else if (w < 20)
                pos = (op == OP_INSERT || cnt == 0) ? cnt : cnt - 1;
            else if (w < 85)
                pos = (op == OP_INSERT || cnt == 0) ? $urandom_range(0, cnt)
                                                    : $urandom_range(0, cnt - 1);
            else
            begin
                case ($urandom_range(0, 3))
                    0: pos = cnt;
                    1: pos = cnt + 1;
                    2: pos = 1024;
                    default: pos = $urandom_range(cnt, 1024);
                endcase
            end

            case ($urandom_range(0, 7))
                0:
                begin
                    case ($urandom_range(0, 3))
                        0: val = 32'sh8000_0000;
                        1: val = 32'sh7fff_ffff;
                        2: val = -1;
                        default: val = 0;
                    endcase
                end
                1, 2: val = $signed($urandom_range(0, 16)) - 8;
                default: val = $urandom;
            endcase

            send_cmd(op, pos, val);
        end

        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (board.waiting() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (board.errors == 0 && board.waiting() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/ple_pkg.sv
rtl/ple_cmd_if.sv
rtl/ple_res_if.sv
rtl/positional_list_engine.sv
dv/ple_tb_pkg.sv
dv/tb_top.sv
